// ----- sv/wslq_pkg.sv -----
// ----------------------------------------------------------------------------
// wslq_pkg: shared types and constants of the work stealing lane queue
// Command codes, register indexes, descriptor widths and APB bus widths.
// ----------------------------------------------------------------------------
package wslq_pkg;

	// Width of the handle word and of the argument word of a descriptor.
	localparam int unsigned WORD_W = 64;

	// Width of a whole stored descriptor (handle above argument).
	localparam int unsigned DESC_W = 2 * WORD_W;

	// Width of the APB data bus and of the APB address.
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	// Command codes of an input item.
	typedef enum logic [1:0] {
		CMD_SUBMIT = 2'd0,
		CMD_TAKE   = 2'd1,
		CMD_DONE   = 2'd2
	} cmd_t;

	// Register indexes, taken from address bit 2.
	localparam logic REG_LANES_IN_USE = 1'b0;
	localparam logic REG_LANE_SLOTS   = 1'b1;

endpackage

// ----- sv/work_stealing_lane_queue.sv -----
// ----------------------------------------------------------------------------
// work_stealing_lane_queue: per-lane descriptor rings with work stealing
// Round-robin submit, take that steals from the next busy lane, done count.
// ----------------------------------------------------------------------------
// An item is accepted when start is high while busy is low. A submit or a
// take then scans from one lane up to the effective lane count, a take
// also passes through the registered read of the slot memory, and a done or
// an unused command is answered from the accept alone. The scan is a single
// lane compare that the sequencer steps over the lanes, and the take result
// waits on the single read port of the slot memory. Each result is shown for
// exactly one cycle with result_valid high; the receiver cannot stall it, and
// busy is already low in that cycle, so the next item may be started while
// the result is taken. Any configuration write flushes every lane and the
// submit pointer but keeps the active count. The slot memory has no reset and
// needs no clearing pass, because a slot is read only after it was written.
// ----------------------------------------------------------------------------
module work_stealing_lane_queue #(
	parameter int unsigned LANES          = 4,
	parameter int unsigned SLOTS_PER_LANE = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,

	// APB configuration port.
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [wslq_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [wslq_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [wslq_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready,

	// Command channel.
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         cmd,
	input  logic [1:0]                         preferred_lane,
	input  logic [wslq_pkg::WORD_W-1:0]        job_handle,
	input  logic [wslq_pkg::WORD_W-1:0]        job_argument,

	// Result channel.
	output logic                               result_valid,
	output logic                               ok,
	output logic [1:0]                         lane_used,
	output logic [wslq_pkg::WORD_W-1:0]        taken_handle,
	output logic [wslq_pkg::WORD_W-1:0]        taken_argument,
	output logic [5:0]                         pending_total,
	output logic [7:0]                         active_count,
	output logic                               drained
);

	import wslq_pkg::*;

	// Lane index, lane count, slot index, fill count, pending count, address.
	localparam int unsigned LW    = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int unsigned LNW   = $clog2(LANES + 1);
	localparam int unsigned IW    = (SLOTS_PER_LANE > 1) ? $clog2(SLOTS_PER_LANE) : 1;
	localparam int unsigned FW    = $clog2(SLOTS_PER_LANE + 1);
	localparam int unsigned DEPTH = LANES * SLOTS_PER_LANE;
	localparam int unsigned PW    = $clog2(DEPTH + 1);
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ
	} state_t;

	// Configuration registers.
	logic [2:0]           lanes_cfg_q;
	logic [3:0]           slots_cfg_q;

	// Queue state.
	logic [FW-1:0]        fill_q [LANES];
	logic [IW-1:0]        widx_q [LANES];
	logic [IW-1:0]        ridx_q [LANES];
	logic [LW-1:0]        sp_q;
	logic [PW-1:0]        pending_q;
	logic [7:0]           busy_q;

	// Sequencer and the latched item.
	state_t               state_q;
	cmd_t                 cmd_q;
	logic [LW-1:0]        ln_q;
	logic [LNW-1:0]       cnt_q;
	logic [WORD_W-1:0]    handle_q;
	logic [WORD_W-1:0]    arg_q;

	// Slot memory and its registered read data.
	logic [DESC_W-1:0]    slot_store_q [DEPTH];
	logic [DESC_W-1:0]    rd_data_q;

	// Registered result.
	logic                 result_valid_q;
	logic                 ok_q;
	logic [1:0]           lane_used_q;
	logic [WORD_W-1:0]    taken_handle_q;
	logic [WORD_W-1:0]    taken_argument_q;
	logic [5:0]           pending_total_q;
	logic [7:0]           active_count_q;
	logic                 drained_q;

	logic                 cfg_wr;
	logic                 accept;
	logic [LNW-1:0]       n_eff;
	logic [FW-1:0]        slots_eff;
	logic [LW-1:0]        pref_start;
	logic [LW-1:0]        sp_next;
	logic [LW-1:0]        ln_next;
	logic [FW-1:0]        fill_cur;
	logic [IW-1:0]        widx_cur;
	logic [IW-1:0]        ridx_cur;
	logic [IW-1:0]        widx_next;
	logic [IW-1:0]        ridx_next;
	logic                 hit;
	logic                 last_lane;
	logic                 mem_we;
	logic                 mem_re;
	logic [AW-1:0]        mem_addr;

	// Reduces a preferred lane modulo the lane count; the lane is at most
	// three, so three compare and subtract steps always finish the job.
	function automatic logic [LW-1:0] pref_mod(input logic [1:0] p, input logic [LNW-1:0] n);
		logic [LNW:0] r;
		r = (LNW + 1)'(p);
		for (int k = 0; k < 3; k++) begin
			if (r >= {1'b0, n}) begin
				r = r - {1'b0, n};
			end
		end
		return LW'(r);
	endfunction

	assign cfg_wr = psel && penable && pwrite && pready;
	assign accept = start && !busy;
	assign pready = 1'b1;
	assign busy   = (state_q != ST_IDLE);

	always_comb begin
		unique case (paddr[2])
			REG_LANES_IN_USE: prdata = APB_DATA_W'(lanes_cfg_q);
			REG_LANE_SLOTS:   prdata = APB_DATA_W'(slots_cfg_q);
			default:          prdata = '0;
		endcase
	end

	// Effective lane count and ring size, a zero read as one and larger values clamped to the built capacity.
	always_comb begin
		if (lanes_cfg_q == 3'd0) begin
			n_eff = LNW'(1);
		end else if (32'(lanes_cfg_q) > LANES) begin
			n_eff = LNW'(LANES);
		end else begin
			n_eff = LNW'(lanes_cfg_q);
		end
		if (slots_cfg_q == 4'd0) begin
			slots_eff = FW'(1);
		end else if (32'(slots_cfg_q) > SLOTS_PER_LANE) begin
			slots_eff = FW'(SLOTS_PER_LANE);
		end else begin
			slots_eff = FW'(slots_cfg_q);
		end
	end

	// The shared lane compare and the wrap logic of the lane being scanned.
	always_comb begin
		pref_start = pref_mod(preferred_lane, n_eff);
		sp_next    = ((LNW'(sp_q) + LNW'(1)) == n_eff) ? '0 : LW'(sp_q + LW'(1));
		ln_next    = ((LNW'(ln_q) + LNW'(1)) == n_eff) ? '0 : LW'(ln_q + LW'(1));
		fill_cur   = fill_q[ln_q];
		widx_cur   = widx_q[ln_q];
		ridx_cur   = ridx_q[ln_q];
		widx_next  = ((FW'(widx_cur) + FW'(1)) >= slots_eff) ? '0 : IW'(widx_cur + IW'(1));
		ridx_next  = ((FW'(ridx_cur) + FW'(1)) >= slots_eff) ? '0 : IW'(ridx_cur + IW'(1));
		last_lane  = (cnt_q == (n_eff - LNW'(1)));
		if (cmd_q == CMD_SUBMIT) begin
			hit      = (fill_cur < slots_eff);
			mem_addr = AW'(ln_q * SLOTS_PER_LANE) + AW'(widx_cur);
		end else begin
			hit      = (fill_cur != '0);
			mem_addr = AW'(ln_q * SLOTS_PER_LANE) + AW'(ridx_cur);
		end
		mem_we = (state_q == ST_SCAN) && (cmd_q == CMD_SUBMIT) && hit;
		mem_re = (state_q == ST_SCAN) && (cmd_q == CMD_TAKE) && hit;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_store_q[mem_addr] <= {handle_q, arg_q};
		end
		if (mem_re) begin
			rd_data_q <= slot_store_q[mem_addr];
		end
	end

	// Sequencer, queue state and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_cfg_q    <= 3'd4;
			slots_cfg_q    <= 4'd8;
			for (int l = 0; l < LANES; l++) begin
				fill_q[l] <= '0;
				widx_q[l] <= '0;
				ridx_q[l] <= '0;
			end
			sp_q           <= '0;
			pending_q      <= '0;
			busy_q         <= '0;
			state_q        <= ST_IDLE;
			cmd_q          <= CMD_SUBMIT;
			ln_q           <= '0;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_wr) begin
				// A write to either register flushes every lane.
				if (paddr[2] == REG_LANES_IN_USE) begin
					lanes_cfg_q <= pwdata[2:0];
				end else begin
					slots_cfg_q <= pwdata[3:0];
				end
				for (int l = 0; l < LANES; l++) begin
					fill_q[l] <= '0;
					widx_q[l] <= '0;
					ridx_q[l] <= '0;
				end
				sp_q      <= '0;
				pending_q <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q    <= cmd_t'(cmd);
						handle_q <= job_handle;
						arg_q    <= job_argument;
						cnt_q    <= '0;
						case (cmd)
							CMD_SUBMIT: begin
								// The pointer moves on whether or not the submit
								// finds room.
								ln_q    <= sp_q;
								sp_q    <= sp_next;
								state_q <= ST_SCAN;
							end
							CMD_TAKE: begin
								ln_q    <= pref_start;
								state_q <= ST_SCAN;
							end
							default: begin
								// A done lowers the active count when there is
								// one; an unused command only reports status.
								ok_q             <= 1'b0;
								if (cmd == CMD_DONE && busy_q != 8'd0) begin
									busy_q         <= busy_q - 8'd1;
									ok_q           <= 1'b1;
									active_count_q <= busy_q - 8'd1;
									drained_q      <= (pending_q == '0) && (busy_q == 8'd1);
								end else begin
									active_count_q <= busy_q;
									drained_q      <= (pending_q == '0) && (busy_q == 8'd0);
								end
								lane_used_q      <= 2'd0;
								taken_handle_q   <= '0;
								taken_argument_q <= '0;
								pending_total_q  <= 6'(pending_q);
								result_valid_q   <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit && cmd_q == CMD_SUBMIT) begin
						widx_q[ln_q]     <= widx_next;
						fill_q[ln_q]     <= fill_cur + FW'(1);
						pending_q        <= pending_q + PW'(1);
						ok_q             <= 1'b1;
						lane_used_q      <= 2'(ln_q);
						taken_handle_q   <= '0;
						taken_argument_q <= '0;
						pending_total_q  <= 6'(pending_q + PW'(1));
						active_count_q   <= busy_q;
						drained_q        <= 1'b0;
						result_valid_q   <= 1'b1;
						state_q          <= ST_IDLE;
					end else if (hit) begin
						// The slot is read this cycle; the result follows it.
						ridx_q[ln_q] <= ridx_next;
						fill_q[ln_q] <= fill_cur - FW'(1);
						if (pending_q != '0) begin
							pending_q <= pending_q - PW'(1);
						end
						if (busy_q != 8'd255) begin
							busy_q <= busy_q + 8'd1;
						end
						state_q <= ST_READ;
					end else if (last_lane) begin
						// Every lane was full for a submit or empty for a take.
						ok_q             <= 1'b0;
						lane_used_q      <= 2'd0;
						taken_handle_q   <= '0;
						taken_argument_q <= '0;
						pending_total_q  <= 6'(pending_q);
						active_count_q   <= busy_q;
						drained_q        <= (pending_q == '0) && (busy_q == 8'd0);
						result_valid_q   <= 1'b1;
						state_q          <= ST_IDLE;
					end else begin
						ln_q  <= ln_next;
						cnt_q <= cnt_q + LNW'(1);
					end
				end
				ST_READ: begin
					ok_q             <= 1'b1;
					lane_used_q      <= 2'(ln_q);
					taken_handle_q   <= rd_data_q[DESC_W-1:WORD_W];
					taken_argument_q <= rd_data_q[WORD_W-1:0];
					pending_total_q  <= 6'(pending_q);
					active_count_q   <= busy_q;
					drained_q        <= (pending_q == '0) && (busy_q == 8'd0);
					result_valid_q   <= 1'b1;
					state_q          <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid   = result_valid_q;
	assign ok             = ok_q;
	assign lane_used      = lane_used_q;
	assign taken_handle   = taken_handle_q;
	assign taken_argument = taken_argument_q;
	assign pending_total  = pending_total_q;
	assign active_count   = active_count_q;
	assign drained        = drained_q;

`ifndef NO_ASSERTIONS
	// A result is only ever shown once the sequencer is back at rest.
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result shown while busy");

	// A submit or take passes through the scan state before its result is shown.
	a_scan_delay: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd == CMD_SUBMIT || cmd == CMD_TAKE)) |=> !result_valid)
		else $error("scan command answered without a scan");

	// A done or an unused command is answered in the next cycle.
	a_done_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd != CMD_SUBMIT && cmd != CMD_TAKE) |=> result_valid)
		else $error("done command not answered");

	// A take that finds an item always raises or holds a saturated count.
	a_take_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (busy_q != 8'd0))
		else $error("active count zero after a take");
`endif

endmodule
